### sv/eelt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eelt_pkg
// Shared types and constants of the error event log table.
// ----------------------------------------------------------------------------
package eelt_pkg;

  localparam logic [15:0] NO_ERROR_CODE = 16'd0;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  localparam logic FUNC_REPORT = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  // One log slot as held in the slot memory
  typedef struct packed {
    logic [15:0] code;
    logic [15:0] count;
    logic [31:0] stamp;
    logic [15:0] param;
  } eelt_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RDLAT = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_WB    = 4'b1000
  } eelt_state_t;

  function automatic eelt_entry_t eelt_record(eelt_entry_t e, logic [15:0] code,
                                              logic [15:0] param, logic [31:0] stamp);
    eelt_entry_t r;
    r       = e;
    r.code  = code;
    r.count = (e.count == COUNT_MAX) ? e.count : e.count + 16'd1;
    r.param = param;
    r.stamp = stamp;
    return r;
  endfunction

endpackage

### sv/eelt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eelt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module eelt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/error_event_log_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// error_event_log_table_top
// Error event log: per-code occurrence counts, last parameter and time stamp.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transfer:
//   func 0 reports an error event, func 1 reads one log slot. Every command
//   produces exactly one transfer on the output channel (out_valid/out_ready).
//   Slot contents live in one synchronous RAM (one read per cycle, registered
//   read data); a report walks the slots one per cycle starting at slot 0
//   and stops at the first slot that matches its code (slot 0 matches on
//   other_error_code) or, past slot 0, is empty; if none does, it falls
//   back to slot zero as overflow. An in-range read passes a read-latency
//   state into write-back; a code-zero report goes straight to write-back.
//   The next command is taken as soon as the block is back in idle, even
//   while the previous result still sits in the output register; if the
//   receiver stalls, the new command finishes its work and then holds in
//   write-back until the output register frees up.
//   Reset clears every slot through per-slot valid bits (no clearing pass),
//   zeroes the latest-error register and sets other_error_code to 1.
//   cfg_write_en/cfg_write_data write other_error_code; write it only while
//   the block is idle.
// ----------------------------------------------------------------------------
module error_event_log_table_top #(
  parameter int LOG_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [15:0] report_code,
  input  logic [15:0] event_parameter,
  input  logic [31:0] event_time,
  input  logic [2:0]  slot_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  slot_used,
  output logic [15:0] slot_code,
  output logic [15:0] slot_count,
  output logic [31:0] slot_time,
  output logic [15:0] slot_parameter,
  output logic [15:0] latest_error,
  output logic        was_ignored,
  output logic        went_to_overflow
);

  import eelt_pkg::*;

  localparam int AW = $clog2(LOG_SLOTS);
  localparam int EW = $bits(eelt_entry_t);
  localparam logic [AW-1:0] LAST_SLOT = AW'(LOG_SLOTS - 1);

  eelt_state_t       state;
  logic [15:0]       other_code;
  logic [15:0]       last_err;
  logic [LOG_SLOTS-1:0] valid;

  // Command held for the duration of the work
  logic [15:0]       cmd_code;
  logic [15:0]       cmd_param;
  logic [31:0]       cmd_stamp;
  logic              cmd_write;   // write-back needed at the end
  logic              cmd_blank;   // result shows an all-zero slot
  logic              cmd_ovf;
  logic              cmd_ign;

  logic [AW-1:0]     chk;         // slot whose data sits on the RAM output
  logic [AW-1:0]     wslot;
  logic [2:0]        wslot_num;
  eelt_entry_t       cur;
  eelt_entry_t       slot0;

  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;
  eelt_entry_t       ent;
  logic              hit;
  logic              in_fire;
  logic              out_free;
  logic              in_range;
  logic [AW-1:0]     first_slot;

  assign in_ready   = (state == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign in_range   = ({29'd0, slot_index} < 32'(LOG_SLOTS));
  assign ram_we     = (state == ST_WB) && out_free && cmd_write;
  // A read looks at its own slot; a report starts its walk at slot zero
  assign first_slot = (func == FUNC_READ && in_range) ? AW'(slot_index) : '0;

  // Slot on the RAM output, empty until first written after reset
  assign ent = valid[chk] ? eelt_entry_t'(ram_rdata) : '0;

  // Slot zero matches on the register code; the others match or are free
  always_comb begin
    if (chk == '0) begin
      hit = (other_code == cmd_code);
    end else begin
      hit = (ent.code == cmd_code) || (ent.code == NO_ERROR_CODE);
    end
  end

  // Read address: first slot at accept, then advance one slot per cycle
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (in_fire) begin
      ram_re    = 1'b1;
      ram_raddr = first_slot;
    end else if (state == ST_SCAN && !hit && chk != LAST_SLOT) begin
      ram_re    = 1'b1;
      ram_raddr = chk + AW'(1);
    end
  end

  eelt_ram #(
    .WIDTH (EW),
    .DEPTH (LOG_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wslot),
    .wdata (cur),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      other_code <= 16'd1;
      last_err   <= 16'd0;
      valid      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        other_code <= cfg_write_data;
      end
      // Load the result register out of write-back, drop it once taken
      if (state == ST_WB && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (func == FUNC_READ) begin
              state <= in_range ? ST_RDLAT : ST_WB;
            end else if (report_code == NO_ERROR_CODE) begin
              state <= ST_WB;
            end else begin
              last_err <= report_code;
              state    <= ST_SCAN;
            end
          end
        end
        ST_RDLAT: begin
          state <= ST_WB;
        end
        ST_SCAN: begin
          if (hit || chk == LAST_SLOT) begin
            state <= ST_WB;
          end
        end
        ST_WB: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (cmd_write) begin
              valid[wslot] <= 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: command capture, slot walk and result register
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_code  <= report_code;
          cmd_param <= event_parameter;
          cmd_stamp <= event_time;
          cmd_ovf   <= 1'b0;
          cmd_ign   <= (func == FUNC_REPORT) && (report_code == NO_ERROR_CODE);
          cmd_write <= (func == FUNC_REPORT) && (report_code != NO_ERROR_CODE);
          cmd_blank <= (func == FUNC_READ) ? !in_range : (report_code == NO_ERROR_CODE);
          chk       <= first_slot;
          wslot     <= first_slot;
          wslot_num <= (func == FUNC_READ) ? slot_index : 3'd0;
          cur       <= '0;
        end
      end
      ST_RDLAT: begin
        cur <= ent;
      end
      ST_SCAN: begin
        if (chk == '0) begin
          slot0 <= ent;
        end
        if (hit) begin
          cur       <= eelt_record(ent, cmd_code, cmd_param, cmd_stamp);
          wslot     <= chk;
          wslot_num <= 3'(chk);
        end else if (chk == LAST_SLOT) begin
          // Nothing matched or free: slot zero takes it as overflow
          cur       <= eelt_record(slot0, cmd_code, cmd_param, cmd_stamp);
          wslot     <= '0;
          wslot_num <= 3'd0;
          cmd_ovf   <= 1'b1;
        end else begin
          chk <= chk + AW'(1);
        end
      end
      ST_WB: begin
        if (out_free) begin
          slot_used        <= wslot_num;
          slot_code        <= cmd_blank ? 16'd0 : ((wslot == '0) ? other_code : cur.code);
          slot_count       <= cmd_blank ? 16'd0 : cur.count;
          slot_time        <= cmd_blank ? 32'd0 : cur.stamp;
          slot_parameter   <= cmd_blank ? 16'd0 : cur.param;
          latest_error     <= last_err;
          was_ignored      <= cmd_ign;
          went_to_overflow <= cmd_ovf;
        end
      end
      default: begin
      end
    endcase
  end

  // Overflow always lands in slot zero and never comes from an ignored report
  a_ovf_slot0: assert property (@(posedge clk) disable iff (rst)
    out_valid && went_to_overflow |-> slot_used == 3'd0 && !was_ignored)
    else $error("overflow result not in slot zero");

  // An ignored report shows an empty slot
  a_ign_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_ignored |-> slot_code == 16'd0 && slot_count == 16'd0)
    else $error("ignored report shows slot contents");

  // A result appears only out of write-back
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_WB)
    else $error("result loaded outside write-back");

  // A written slot is marked filled
  a_valid_set: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> valid[$past(wslot)])
    else $error("written slot not marked valid");

  // A recorded report never leaves a zero count behind
  a_count_nz: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> cur.count != 16'd0)
    else $error("recorded slot with zero count");

endmodule
